// ===== design/assert_macros.svh =====
// Assertion macros shared by the join copy-and-compact RTL.
// Define ASSERT_OFF to compile all checks away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/jcc_pkg.sv =====
// Shared types and constants for the join copy-and-compact block.
// No dependencies; used by every module of the block except jcc_ram.
package jcc_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int VALUE_W         = 32;

   localparam logic [VALUE_W-1:0] ID_LEFT  = 32'd1;
   localparam logic [VALUE_W-1:0] ID_RIGHT = 32'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_COPY_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COPY_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COLUMNS = 2'd2;

   localparam int FIRST_W = 4;
   localparam int END_W   = 5;
   localparam int COLS_W  = 5;
   localparam logic [COLS_W-1:0] ROW_COLUMNS_RST = 5'd16;

   typedef struct packed {
      logic [FIRST_W-1:0] copy_first;
      logic [END_W-1:0]   copy_end;
      logic [COLS_W-1:0]  row_columns;
   } cfg_type;

   typedef struct packed {
      logic               load;
      logic [VALUE_W-1:0] value;
      logic               last;
   } emit_type;

endpackage

// ===== design/join_copy_and_compact.sv =====
// Top level of the join copy-and-compact block: config registers, row
// sequencer and result register. Depends on jcc_pkg, jcc_csr, jcc_ctrl.
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_value
// rsp      out  rsp_valid/rsp_ready    rsp_value_res, rsp_last_of_row
// csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// Non-final columns are buffered as they arrive. The final column runs the id,
// key, sweep and tag states, sweeping up to max(columns seen, row width) columns
// through the shared select unit and both row buffers, stalling on a full result.
// Synchronous active-high reset clears control state; the row buffers are not
// cleared. Configuration writes are always taken (csr_ready is tied high).
module join_copy_and_compact #(
   parameter int MAX_COLUMNS = jcc_pkg::MAX_COLUMNS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [jcc_pkg::VALUE_W-1:0]      req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [jcc_pkg::VALUE_W-1:0]      rsp_value_res,
   output logic                             rsp_last_of_row,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   jcc_pkg::cfg_type  cfg;
   jcc_pkg::emit_type emit;
   logic                          slot_free;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [jcc_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   assign csr_ready = 1'b1;

   jcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jcc_ctrl #(.MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .slot_free (slot_free),
      .emit      (emit)
   );

   // result register: refilled in the cycle the held transaction leaves
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = emit.value;
         rsp_last_in  = emit.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_res   = rsp_value_ff;
   assign rsp_last_of_row = rsp_last_ff;

endmodule

// ===== design/jcc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/jcc_csr.sv =====
// Configuration registers of the join copy-and-compact block.
// Depends on jcc_pkg.
module jcc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [jcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jcc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output jcc_pkg::cfg_type                 cfg
);

   jcc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            jcc_pkg::CSR_COPY_FIRST:  cfg_in.copy_first  = csr_wdata[jcc_pkg::FIRST_W-1:0];
            jcc_pkg::CSR_COPY_END:    cfg_in.copy_end    = csr_wdata[jcc_pkg::END_W-1:0];
            jcc_pkg::CSR_ROW_COLUMNS: cfg_in.row_columns = csr_wdata[jcc_pkg::COLS_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.copy_first  <= '0;
         cfg_ff.copy_end    <= '0;
         cfg_ff.row_columns <= jcc_pkg::ROW_COLUMNS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/jcc_ctrl.sv =====
// Row sequencer: buffers a row, resolves tag and copy, then sweeps the columns
// through one shared range/select unit. Depends on jcc_pkg, jcc_ram, assert_macros.svh.
`include "assert_macros.svh"
module jcc_ctrl #(
   parameter int MAX_COLUMNS = jcc_pkg::MAX_COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  jcc_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jcc_pkg::VALUE_W-1:0]   req_value,
   input  logic                          slot_free,
   output jcc_pkg::emit_type             emit
);

   localparam int CIW = $clog2(MAX_COLUMNS);
   localparam int NW  = $clog2(MAX_COLUMNS + 1);
   localparam int CW  = (NW + 1 > 6) ? NW + 1 : 6;
   localparam int VW  = jcc_pkg::VALUE_W;

   localparam logic [2:0] S_COLLECT = 3'd0;
   localparam logic [2:0] S_ID      = 3'd1;
   localparam logic [2:0] S_KEY     = 3'd2;
   localparam logic [2:0] S_SWEEP   = 3'd3;
   localparam logic [2:0] S_TAG     = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [CIW-1:0]           cc_ff, cc_in;
   logic [NW-1:0]            n_ff, n_in;
   logic [NW-1:0]            hi_ff, hi_in;
   logic [CIW-1:0]           j_ff, j_in;
   logic [VW-1:0]            key_ff, key_in;
   logic [jcc_pkg::FIRST_W-1:0] first_ff, first_in;
   logic [jcc_pkg::END_W-1:0]   end_ff, end_in;
   logic                     tag_ff, tag_in;
   logic                     docopy_ff, docopy_in;
   logic                     emit_ff, emit_in;
   logic [VW-1:0]            prev_key_ff, prev_key_in;
   logic                     prev_tag_ff, prev_tag_in;
   logic                     have_prev_ff, have_prev_in;
   logic [MAX_COLUMNS-1:0]   wr_ff, wr_in;

   // RAM ports
   logic                     w_we, rd_en, p_we;
   logic [CIW-1:0]           w_waddr, rd_addr;
   logic [VW-1:0]            w_rdata, p_rdata, p_wdata;

   // shared range/select unit
   logic [CIW-1:0]           idx_sel;
   logic [CW-1:0]            idx_w;
   logic                     in_range, cp_en, in_copy;

   logic [CW-1:0]            rc_w, n_w;
   logic [NW-1:0]            n_now, nm1_now, nm2_now, cc_n;
   logic                     accept, row_end;
   logic                     tag_now, docopy_now;
   logic [VW-1:0]            id_final, sweep_val;
   logic                     need_emit, sweep_adv, sweep_last, tag_done;
   logic [CW-1:0]            j_next_w;

   jcc_ram #(.WIDTH(VW), .DEPTH(MAX_COLUMNS)) u_cur_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (req_value),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (w_rdata)
   );

   jcc_ram #(.WIDTH(VW), .DEPTH(MAX_COLUMNS)) u_prev_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (j_ff),
      .wdata (p_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (p_rdata)
   );

   // row width, clamped to [3, MAX_COLUMNS]
   always_comb begin
      rc_w = CW'(cfg.row_columns);
      if (rc_w < CW'(3)) begin
         n_w = CW'(3);
      end else if (rc_w > CW'(MAX_COLUMNS)) begin
         n_w = CW'(MAX_COLUMNS);
      end else begin
         n_w = rc_w;
      end
   end

   assign n_now   = n_w[NW-1:0];
   assign nm1_now = n_now - NW'(1);
   assign nm2_now = n_now - NW'(2);
   assign cc_n    = NW'(cc_ff);

   assign req_ready = (state_ff == S_COLLECT);
   assign accept    = req_valid && req_ready;
   assign row_end   = accept && !((CW'(cc_ff) + CW'(1)) < n_w);

   // shared unit: is column idx_sel inside the copy window of this row
   always_comb begin
      unique case (state_ff)
         S_ID:    idx_sel = CIW'(n_ff - NW'(2));
         S_KEY:   idx_sel = CIW'(n_ff - NW'(1));
         default: idx_sel = j_ff;
      endcase
   end

   assign idx_w    = CW'(idx_sel);
   assign in_range = (idx_w >= CW'(first_ff)) && (idx_w < CW'(end_ff)) &&
                     (idx_w < CW'(n_ff));
   assign cp_en    = (state_ff == S_ID) ? docopy_now : docopy_ff;
   assign in_copy  = cp_en && in_range;

   assign tag_now    = (w_rdata == jcc_pkg::ID_RIGHT) ||
                       (have_prev_ff && (key_ff == prev_key_ff) && prev_tag_ff);
   assign docopy_now = have_prev_ff && (w_rdata == jcc_pkg::ID_LEFT) && tag_now;
   assign id_final   = in_copy ? p_rdata : w_rdata;

   assign sweep_val  = (in_copy || !wr_ff[j_ff]) ? p_rdata : w_rdata;
   assign need_emit  = emit_ff && ((CW'(j_ff) + CW'(2)) < CW'(n_ff));
   assign sweep_adv  = (state_ff == S_SWEEP) && (!need_emit || slot_free);
   assign j_next_w   = CW'(j_ff) + CW'(1);
   assign sweep_last = (j_next_w == CW'(hi_ff));
   assign tag_done   = (state_ff == S_TAG) && (!emit_ff || slot_free);

   always_comb begin
      state_in     = state_ff;
      cc_in        = cc_ff;
      n_in         = n_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      tag_in       = tag_ff;
      docopy_in    = docopy_ff;
      emit_in      = emit_ff;
      prev_key_in  = prev_key_ff;
      prev_tag_in  = prev_tag_ff;
      have_prev_in = have_prev_ff;
      wr_in        = wr_ff;
      w_we         = 1'b0;
      w_waddr      = cc_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      p_we         = 1'b0;
      p_wdata      = sweep_val;
      emit.load    = 1'b0;
      emit.value   = sweep_val;
      emit.last    = 1'b0;

      unique case (state_ff)
         S_COLLECT: begin
            if (accept) begin
               w_we = 1'b1;
               if (row_end) begin
                  w_waddr  = nm1_now[CIW-1:0];
                  key_in   = req_value;
                  n_in     = n_now;
                  hi_in    = (cc_n > n_now) ? cc_n : n_now;
                  first_in = cfg.copy_first;
                  end_in   = cfg.copy_end;
                  rd_en    = 1'b1;
                  rd_addr  = nm2_now[CIW-1:0];
                  state_in = S_ID;
               end else begin
                  cc_in = cc_ff + CIW'(1);
               end
               wr_in[w_waddr] = 1'b1;
            end
         end
         S_ID: begin
            tag_in    = tag_now;
            docopy_in = docopy_now;
            emit_in   = (id_final == jcc_pkg::ID_LEFT);
            rd_en     = 1'b1;
            rd_addr   = CIW'(n_ff - NW'(1));
            state_in  = S_KEY;
         end
         S_KEY: begin
            prev_key_in  = in_copy ? p_rdata : key_ff;
            prev_tag_in  = tag_ff;
            have_prev_in = 1'b1;
            j_in         = '0;
            rd_en        = 1'b1;
            rd_addr      = '0;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            if (sweep_adv) begin
               p_we      = 1'b1;
               emit.load = need_emit;
               if (sweep_last) begin
                  state_in = S_TAG;
               end else begin
                  j_in    = j_ff + CIW'(1);
                  rd_en   = 1'b1;
                  rd_addr = j_ff + CIW'(1);
               end
            end
         end
         S_TAG: begin
            emit.value = VW'(tag_ff);
            emit.last  = 1'b1;
            if (tag_done) begin
               emit.load = emit_ff;
               wr_in     = '0;
               cc_in     = '0;
               state_in  = S_COLLECT;
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         cc_ff        <= '0;
         wr_ff        <= '0;
         prev_key_ff  <= '0;
         prev_tag_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         wr_ff        <= wr_in;
         prev_key_ff  <= prev_key_in;
         prev_tag_ff  <= prev_tag_in;
         have_prev_ff <= have_prev_in;
         emit_ff      <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      hi_ff     <= hi_in;
      j_ff      <= j_in;
      key_ff    <= key_in;
      first_ff  <= first_in;
      end_ff    <= end_in;
      tag_ff    <= tag_in;
      docopy_ff <= docopy_in;
   end

   `ASSERT_IMPLY(a_load_needs_slot, clock, reset, emit.load, slot_free)
   `ASSERT_IMPLY(a_last_only_tag, clock, reset, emit.load && emit.last, state_ff == S_TAG)
   `ASSERT_NEXT(a_row_end_to_id, clock, reset, row_end, state_ff == S_ID && !req_ready)
   `ASSERT_NEXT(a_tag_clears_row, clock, reset, tag_done, wr_ff == '0 && cc_ff == '0)
   `ASSERT_IMPLY(a_sweep_in_bounds, clock, reset, state_ff == S_SWEEP, CW'(j_ff) < CW'(hi_ff))

endmodule
